FILE: sv/primitive_collision_tester_assert.svh
// Assertion helpers for the collision tester checker.
`ifndef PRIMITIVE_COLLISION_TESTER_ASSERT_SVH
`define PRIMITIVE_COLLISION_TESTER_ASSERT_SVH

// Condition holds, consequence in the same cycle.
`define PCT_ASSERT_NOW(lbl, clk, rst, cond, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("pct assertion failed");

// Condition holds, consequence from the next cycle on.
`define PCT_ASSERT_NEXT(lbl, clk, rst, cond, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("pct assertion failed");

`endif

FILE: sv/pct_pkg.sv
`timescale 1ns / 1ps
package pct_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int FIELD_BITS     = 48;
   localparam int RAD_BITS       = 15;
   localparam int OP_BITS        = 3;
   localparam int LW             = 40;   // working width of the clamp helper
   localparam int T_BITS         = 17;   // Q0.16 plus the value one
   localparam int DIV_STAGES     = 8;
   localparam int DIV_STEPS      = 2;    // quotient bits per stage
   localparam int FRONT_LAT      = 4;
   localparam int CS_LAT         = 3 + DIV_STAGES + 4;
   localparam int RSP_LAT        = CS_LAT + 1;

   typedef enum logic [OP_BITS-1:0] {
      OP_SPH_SPH = 3'd0,
      OP_BOX_BOX = 3'd1,
      OP_SPH_BOX = 3'd2,
      OP_CAP_BOX = 3'd3,
      OP_CAP_SPH = 3'd4
   } op_type;

   // lo checked first, then hi
   function automatic logic signed [LW-1:0] clampw(input logic signed [LW-1:0] n,
                                                   input logic signed [LW-1:0] lo,
                                                   input logic signed [LW-1:0] hi);
      logic signed [LW-1:0] r;
      if (n < lo) r = lo;
      else if (n > hi) r = hi;
      else r = n;
      return r;
   endfunction

endpackage

FILE: sv/pct_front.sv
`timescale 1ns / 1ps
module pct_front import pct_pkg::*; #(
   parameter int CB = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic [OP_BITS-1:0]    op,
   input  logic [FIELD_BITS-1:0] a_first,
   input  logic [FIELD_BITS-1:0] a_second,
   input  logic [FIELD_BITS-1:0] b_first,
   input  logic [FIELD_BITS-1:0] b_second,
   input  logic [RAD_BITS-1:0]   a_radius,
   input  logic [RAD_BITS-1:0]   b_radius,
   output logic                  hit
);
   localparam int PW = (3*CB > FIELD_BITS) ? 3*CB : FIELD_BITS;
   localparam int DW = CB + 3;
   localparam int SW = 2*DW;
   localparam int RW = RAD_BITS + 1;

   logic [PW-1:0] pa1, pa2, pb1, pb2;
   logic signed [CB-1:0] a1 [3];
   logic signed [CB-1:0] a2 [3];
   logic signed [CB-1:0] b1 [3];
   logic signed [CB-1:0] b2 [3];

   assign pa1 = PW'(a_first);
   assign pa2 = PW'(a_second);
   assign pb1 = PW'(b_first);
   assign pb2 = PW'(b_second);

   for (genvar i = 0; i < 3; i++) begin : g_lane
      assign a1[i] = $signed(pa1[i*CB +: CB]);
      assign a2[i] = $signed(pa2[i*CB +: CB]);
      assign b1[i] = $signed(pb1[i*CB +: CB]);
      assign b2[i] = $signed(pb2[i*CB +: CB]);
   end

   // stage A: clamps, box overlap, radius selection
   logic [OP_BITS-1:0]     op_a_ff;
   logic [RW-1:0]          r_a_ff, r_a_in;
   logic                   box_a_ff, box_a_in;
   logic signed [CB:0]     ld_a_ff [3];
   logic signed [CB-1:0]   q_a_ff  [3];
   logic signed [CB-1:0]   a1_a_ff [3];
   logic signed [CB:0]     py2_a_ff, ly2_a_ff, hy2_a_ff;
   logic signed [CB:0]     py2_a_in, ymin2, ymax2;

   always_comb begin
      box_a_in = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (a2[i] < b1[i] || a1[i] > b2[i]) box_a_in = 1'b0;
      end
      ymin2 = (a1[1] < a2[1]) ? {a1[1], 1'b0} : {a2[1], 1'b0};
      ymax2 = (a1[1] < a2[1]) ? {a2[1], 1'b0} : {a1[1], 1'b0};
      py2_a_in = (CB+1)'(clampw(LW'((CB+1)'(b1[1]) + (CB+1)'(b2[1])),
                                LW'(ymin2), LW'(ymax2)));
      unique case (op)
         OP_SPH_SPH: r_a_in = RW'(a_radius) + RW'(b_radius);
         OP_SPH_BOX: r_a_in = RW'(a_radius);
         OP_CAP_BOX: r_a_in = {a_radius, 1'b0};
         default:    r_a_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      op_a_ff  <= op;
      r_a_ff   <= r_a_in;
      box_a_ff <= box_a_in;
      py2_a_ff <= py2_a_in;
      ly2_a_ff <= {b1[1], 1'b0};
      hy2_a_ff <= {b2[1], 1'b0};
      for (int i = 0; i < 3; i++) begin
         ld_a_ff[i] <= (CB+1)'(a1[i]) - (CB+1)'(b1[i]);
         q_a_ff[i]  <= CB'(clampw(LW'(a1[i]), LW'(b1[i]), LW'(b2[i])));
         a1_a_ff[i] <= a1[i];
      end
   end

   // stage B: per-lane offsets, scaled so that each test is sum d^2 <= r^2
   logic [OP_BITS-1:0]   op_b_ff;
   logic [RW-1:0]        r_b_ff;
   logic                 box_b_ff;
   logic signed [DW-1:0] d_b_ff [3];
   logic signed [DW-1:0] d_b_in [3];
   logic signed [DW-1:0] qd [3];
   logic signed [CB:0]   qy2;

   always_comb begin
      qy2 = (CB+1)'(clampw(LW'(py2_a_ff), LW'(ly2_a_ff), LW'(hy2_a_ff)));
      for (int i = 0; i < 3; i++) begin
         qd[i] = DW'(a1_a_ff[i]) - DW'(q_a_ff[i]);
      end
      unique case (op_a_ff)
         OP_SPH_SPH: begin
            for (int i = 0; i < 3; i++) d_b_in[i] = DW'(ld_a_ff[i]);
         end
         OP_SPH_BOX: begin
            for (int i = 0; i < 3; i++) d_b_in[i] = qd[i];
         end
         OP_CAP_BOX: begin
            d_b_in[0] = qd[0] <<< 1;
            d_b_in[1] = DW'(py2_a_ff) - DW'(qy2);
            d_b_in[2] = qd[2] <<< 1;
         end
         default: begin
            for (int i = 0; i < 3; i++) d_b_in[i] = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_b_ff  <= op_a_ff;
      r_b_ff   <= r_a_ff;
      box_b_ff <= box_a_ff;
      for (int i = 0; i < 3; i++) d_b_ff[i] <= d_b_in[i];
   end

   // stage C: squares
   logic [OP_BITS-1:0] op_c_ff;
   logic               box_c_ff;
   logic [SW-1:0]      sq_c_ff [3];
   logic [2*RW-1:0]    rr_c_ff;

   always_ff @(posedge clock) begin
      op_c_ff  <= op_b_ff;
      box_c_ff <= box_b_ff;
      rr_c_ff  <= r_b_ff * r_b_ff;
      for (int i = 0; i < 3; i++) sq_c_ff[i] <= SW'(d_b_ff[i] * d_b_ff[i]);
   end

   // stage D: sum, compare, select
   logic [SW+1:0] sum_d;
   logic          hit_ff, hit_in;

   always_comb begin
      sum_d = (SW+2)'(sq_c_ff[0]) + (SW+2)'(sq_c_ff[1]) + (SW+2)'(sq_c_ff[2]);
      unique case (op_c_ff)
         OP_SPH_SPH, OP_SPH_BOX, OP_CAP_BOX: hit_in = (sum_d <= (SW+2)'(rr_c_ff));
         OP_BOX_BOX: hit_in = box_c_ff;
         default:    hit_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) hit_ff <= hit_in;

   assign hit = hit_ff;
endmodule

FILE: sv/pct_capsph.sv
`timescale 1ns / 1ps
module pct_capsph import pct_pkg::*; #(
   parameter int CB = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic [FIELD_BITS-1:0] a_first,
   input  logic [FIELD_BITS-1:0] a_second,
   input  logic [FIELD_BITS-1:0] b_first,
   input  logic [RAD_BITS-1:0]   a_radius,
   input  logic [RAD_BITS-1:0]   b_radius,
   output logic                  hit
);
   localparam int PW = (3*CB > FIELD_BITS) ? 3*CB : FIELD_BITS;
   localparam int KW = CB + 1;
   localparam int LN = 2*KW + 2;
   localparam int PR = KW + T_BITS + 1;
   localparam int EW = KW + 4;
   localparam int RW = RAD_BITS + 1;
   localparam int TF = T_BITS - 1;
   localparam int NS = DIV_STAGES + 1;

   logic [PW-1:0] pa1, pa2, pb1;
   logic signed [CB-1:0] a1 [3];
   logic signed [CB-1:0] a2 [3];
   logic signed [CB-1:0] b1 [3];

   assign pa1 = PW'(a_first);
   assign pa2 = PW'(a_second);
   assign pb1 = PW'(b_first);

   for (genvar i = 0; i < 3; i++) begin : g_lane
      assign a1[i] = $signed(pa1[i*CB +: CB]);
      assign a2[i] = $signed(pa2[i*CB +: CB]);
      assign b1[i] = $signed(pb1[i*CB +: CB]);
   end

   // C1: segment and offset vectors, limited to +-2^30
   logic signed [KW-1:0] ab1_ff [3];
   logic signed [KW-1:0] ap1_ff [3];
   logic signed [CB-1:0] a1_1_ff [3];
   logic signed [CB-1:0] b1_1_ff [3];
   logic [RW-1:0]        rs1_ff;

   always_ff @(posedge clock) begin
      rs1_ff <= RW'(a_radius) + RW'(b_radius);
      for (int i = 0; i < 3; i++) begin
         ab1_ff[i]  <= KW'(clampw(LW'(a2[i]) - LW'(a1[i]),
                                 -(LW'(1) <<< 30), LW'(1) <<< 30));
         ap1_ff[i]  <= KW'(clampw(LW'(b1[i]) - LW'(a1[i]),
                                 -(LW'(1) <<< 30), LW'(1) <<< 30));
         a1_1_ff[i] <= a1[i];
         b1_1_ff[i] <= b1[i];
      end
   end

   // C2: products
   logic signed [2*KW-1:0] abab_ff [3];
   logic signed [2*KW-1:0] abap_ff [3];
   logic signed [KW-1:0]   ab2_ff  [3];
   logic signed [CB-1:0]   a1_2_ff [3];
   logic signed [CB-1:0]   b1_2_ff [3];
   logic [RW-1:0]          rs2_ff;

   always_ff @(posedge clock) begin
      rs2_ff <= rs1_ff;
      for (int i = 0; i < 3; i++) begin
         abab_ff[i] <= ab1_ff[i] * ab1_ff[i];
         abap_ff[i] <= ab1_ff[i] * ap1_ff[i];
         ab2_ff[i]  <= ab1_ff[i];
         a1_2_ff[i] <= a1_1_ff[i];
         b1_2_ff[i] <= b1_1_ff[i];
      end
   end

   // C3: len2, dot, range of t; stage 0 of the divider chain
   logic signed [LN-1:0] len2, dot;
   logic                 tz_in, to_in;

   logic [LN-1:0]        rem_ff [NS];
   logic [LN-1:0]        den_ff [NS];
   logic [TF-1:0]        q_ff   [NS];
   logic                 tz_ff  [NS];
   logic                 to_ff  [NS];
   logic signed [KW-1:0] ab_ff  [NS][3];
   logic signed [CB-1:0] a1_ff  [NS][3];
   logic signed [CB-1:0] b1_ff  [NS][3];
   logic [RW-1:0]        rs_ff  [NS];

   always_comb begin
      len2 = LN'(abab_ff[0]) + LN'(abab_ff[1]) + LN'(abab_ff[2]);
      dot  = LN'(abap_ff[0]) + LN'(abap_ff[1]) + LN'(abap_ff[2]);
      tz_in = (len2 == '0) || (dot <= $signed(LN'(0)));
      to_in = !tz_in && (dot >= len2);
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= dot;
      den_ff[0] <= len2;
      q_ff[0]   <= '0;
      tz_ff[0]  <= tz_in;
      to_ff[0]  <= to_in;
      rs_ff[0]  <= rs2_ff;
      for (int i = 0; i < 3; i++) begin
         ab_ff[0][i] <= ab2_ff[i];
         a1_ff[0][i] <= a1_2_ff[i];
         b1_ff[0][i] <= b1_2_ff[i];
      end
   end

   // restoring division of dot by len2, DIV_STEPS quotient bits per stage
   for (genvar s = 1; s < NS; s++) begin : g_div
      logic [LN-1:0] rem_in;
      logic [TF-1:0] q_in;
      logic [LN:0]   r2;

      always_comb begin
         rem_in = rem_ff[s-1];
         q_in   = q_ff[s-1];
         r2     = '0;
         for (int k = 0; k < DIV_STEPS; k++) begin
            r2 = {rem_in, 1'b0};
            if (r2 >= {1'b0, den_ff[s-1]}) begin
               rem_in = LN'(r2 - {1'b0, den_ff[s-1]});
               q_in   = {q_in[TF-2:0], 1'b1};
            end else begin
               rem_in = LN'(r2);
               q_in   = {q_in[TF-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s] <= rem_in;
         q_ff[s]   <= q_in;
         den_ff[s] <= den_ff[s-1];
         tz_ff[s]  <= tz_ff[s-1];
         to_ff[s]  <= to_ff[s-1];
         rs_ff[s]  <= rs_ff[s-1];
         for (int i = 0; i < 3; i++) begin
            ab_ff[s][i] <= ab_ff[s-1][i];
            a1_ff[s][i] <= a1_ff[s-1][i];
            b1_ff[s][i] <= b1_ff[s-1][i];
         end
      end
   end

   // M1: ab * t
   logic [T_BITS-1:0]    t;
   logic signed [PR-1:0] prod_ff [3];
   logic signed [CB-1:0] a1_m1_ff [3];
   logic signed [CB-1:0] b1_m1_ff [3];
   logic [RW-1:0]        rs_m1_ff;

   always_comb begin
      if (tz_ff[NS-1])      t = '0;
      else if (to_ff[NS-1]) t = {1'b1, {TF{1'b0}}};
      else                  t = {1'b0, q_ff[NS-1]};
   end

   always_ff @(posedge clock) begin
      rs_m1_ff <= rs_ff[NS-1];
      for (int i = 0; i < 3; i++) begin
         prod_ff[i]  <= PR'(ab_ff[NS-1][i]) * $signed({1'b0, t});
         a1_m1_ff[i] <= a1_ff[NS-1][i];
         b1_m1_ff[i] <= b1_ff[NS-1][i];
      end
   end

   // M2: closest point and its offset from the sphere centre
   logic signed [EW-1:0] e_ff [3];
   logic [RW-1:0]        rs_m2_ff;

   always_ff @(posedge clock) begin
      rs_m2_ff <= rs_m1_ff;
      for (int i = 0; i < 3; i++) begin
         e_ff[i] <= EW'(a1_m1_ff[i]) + EW'(prod_ff[i] >>> TF) - EW'(b1_m1_ff[i]);
      end
   end

   // M3: squares
   logic [2*EW-1:0] sq_ff [3];
   logic [2*RW-1:0] rr_ff;

   always_ff @(posedge clock) begin
      rr_ff <= rs_m2_ff * rs_m2_ff;
      for (int i = 0; i < 3; i++) sq_ff[i] <= (2*EW)'(e_ff[i] * e_ff[i]);
   end

   // M4: compare
   logic [2*EW+1:0] sum;
   logic            hit_ff;

   assign sum = (2*EW+2)'(sq_ff[0]) + (2*EW+2)'(sq_ff[1]) + (2*EW+2)'(sq_ff[2]);

   always_ff @(posedge clock) hit_ff <= (sum <= (2*EW+2)'(rr_ff));

   assign hit = hit_ff;
endmodule

FILE: sv/primitive_collision_tester.sv
`timescale 1ns / 1ps
// Each start transfer is answered by exactly one rsp_strobe.
// Throughput: one test per cycle; busy stays low outside reset, since the
// receiver cannot stall and each test runs down a fixed-depth pipeline.
// Reset: synchronous, active high; clears all valid bits, busy is high meanwhile.
// Capsule-sphere sets the depth: products, an 8-stage divider (2 bits/stage)
// for the segment parameter, then the closest-point distance test.
module primitive_collision_tester import pct_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_BITS-1:0]    req_opcode,
   input  logic [FIELD_BITS-1:0] req_a_first,
   input  logic [FIELD_BITS-1:0] req_a_second,
   input  logic [RAD_BITS-1:0]   req_a_radius,
   input  logic [FIELD_BITS-1:0] req_b_first,
   input  logic [FIELD_BITS-1:0] req_b_second,
   input  logic [RAD_BITS-1:0]   req_b_radius,
   output logic                  rsp_strobe,
   output logic                  rsp_hit
);
   localparam int FDLY = CS_LAT - FRONT_LAT;

   // no backpressure anywhere, so only reset blocks a transfer
   assign busy = reset;

   // input register: stage 0 of the pipeline
   logic [OP_BITS-1:0]    op_ff;
   logic [FIELD_BITS-1:0] a1_ff, a2_ff, b1_ff, b2_ff;
   logic [RAD_BITS-1:0]   ra_ff, rb_ff;

   always_ff @(posedge clock) begin
      op_ff <= req_opcode;
      a1_ff <= req_a_first;
      a2_ff <= req_a_second;
      b1_ff <= req_b_first;
      b2_ff <= req_b_second;
      ra_ff <= req_a_radius;
      rb_ff <= req_b_radius;
   end

   // valid bits ride alongside the data, one per stage
   logic [CS_LAT:0] vld_ff, vld_in;

   assign vld_in = {vld_ff[CS_LAT-1:0], start && !busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // sphere/box tests: short pipeline
   logic front_hit;

   pct_front #(.CB(COORD_BITS)) u_front (
      .clock    (clock),
      .op       (op_ff),
      .a_first  (a1_ff),
      .a_second (a2_ff),
      .b_first  (b1_ff),
      .b_second (b2_ff),
      .a_radius (ra_ff),
      .b_radius (rb_ff),
      .hit      (front_hit)
   );

   // capsule-sphere: long pipeline with the divider
   logic cs_hit;

   pct_capsph #(.CB(COORD_BITS)) u_capsph (
      .clock    (clock),
      .a_first  (a1_ff),
      .a_second (a2_ff),
      .b_first  (b1_ff),
      .a_radius (ra_ff),
      .b_radius (rb_ff),
      .hit      (cs_hit)
   );

   // align the short path with the long one
   logic [FDLY-1:0]   fhit_ff;
   logic [CS_LAT-1:0] iscs_ff;

   always_ff @(posedge clock) begin
      fhit_ff <= {fhit_ff[FDLY-2:0], front_hit};
      iscs_ff <= {iscs_ff[CS_LAT-2:0], (op_ff == OP_CAP_SPH)};
   end

   assign rsp_strobe = vld_ff[CS_LAT];
   assign rsp_hit    = iscs_ff[CS_LAT-1] ? cs_hit : fhit_ff[FDLY-1];
endmodule

FILE: sv/pct_checker.sv
`timescale 1ns / 1ps
`include "primitive_collision_tester_assert.svh"
module pct_checker import pct_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic [OP_BITS-1:0]    req_opcode,
   input logic [FIELD_BITS-1:0] req_a_first,
   input logic [FIELD_BITS-1:0] req_a_second,
   input logic [FIELD_BITS-1:0] req_b_first,
   input logic [FIELD_BITS-1:0] req_b_second,
   input logic                  rsp_strobe,
   input logic                  rsp_hit
);
   logic xfer, bad_op, box_zero;

   assign xfer     = start && !busy;
   assign bad_op   = req_opcode > OP_CAP_SPH;
   assign box_zero = req_opcode == OP_BOX_BOX && req_a_first == '0 && req_a_second == '0
                     && req_b_first == '0 && req_b_second == '0;

   // every strobe answers an earlier transfer
   `PCT_ASSERT_NOW(a_no_orphan, clock, reset, rsp_strobe, $past(xfer, RSP_LAT))
   // every transfer is answered
   `PCT_ASSERT_NEXT(a_answered, clock, reset, xfer, ##(RSP_LAT-1) rsp_strobe)
   // unused opcodes never hit
   `PCT_ASSERT_NEXT(a_bad_op, clock, reset, xfer && bad_op, ##(RSP_LAT-1) !rsp_hit)
   // box-box with all-zero boxes is always a hit
   `PCT_ASSERT_NEXT(a_box_zero, clock, reset, xfer && box_zero, ##(RSP_LAT-1) rsp_hit)
endmodule

bind primitive_collision_tester pct_checker u_pct_checker (.*);
